### rtl/core/stmin_pkg.sv
// shared types, codes and defaults of the sparse table range minimum engine
`timescale 1ns / 1ps

package stmin_pkg;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 10;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 2;
    localparam int KSEL_W   = 5;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_LEVELS       = 11;
    localparam int DEF_VALUE_WIDTH  = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNBUILT = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  first;
        logic [POS_W-1:0]  second;
        logic [KSEL_W-1:0] level;
        logic              bad_range;
        logic [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0]   minimum;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

### rtl/core/stmin_ram.sv
// generic memory with one write port and two registered read ports
`timescale 1ns / 1ps

module stmin_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/core/stmin_fifo.sv
// small register queue used between the front, the back and the result port
`timescale 1ns / 1ps

module stmin_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PW:0]      r_fill, n_fill;
    logic             w_push, w_pop;

    assign o_full  = (r_fill == (PW+1)'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_fill = r_fill + (PW+1)'(1);
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/stmin_front.sv
// front end: element count register, command decode, query range checks and level select
`timescale 1ns / 1ps

module stmin_front
    import stmin_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int LEVELS       = DEF_LEVELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              i_push,
    output logic              o_full,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [POS_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]  i_left,
    input  logic [POS_W-1:0]  i_right,
    output logic [CNT_W-1:0]  o_active,
    input  logic              i_pop,
    output t_item             o_item,
    output logic              o_empty
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  w_len;
    logic [CNT_W-1:0]  w_second;
    logic [KSEL_W-1:0] w_k;
    logic [KSEL_W-1:0] w_level;
    logic              w_bad;
    logic              w_keep;
    t_item             w_item;
    logic [$bits(t_item)-1:0] w_qdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_wr) begin
            r_count <= i_cfg_data;
        end
    end

    // count saturated to the table size
    assign o_active = (32'(r_count) > 32'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : r_count;

    assign w_len = CNT_W'(i_right) - CNT_W'(i_left) + CNT_W'(1);
    assign w_bad = (i_left > i_right) || (CNT_W'(i_right) >= o_active);

    // floor of log2 of the range length
    always_comb begin
        w_k = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (w_len[b]) begin
                w_k = KSEL_W'(b);
            end
        end
    end

    assign w_level  = (32'(w_k) > LEVELS - 1) ? KSEL_W'(LEVELS - 1) : w_k;
    assign w_second = CNT_W'(i_right) + CNT_W'(1) - (CNT_W'(1) << w_level);

    always_comb begin
        w_item.cmd       = i_command;
        w_item.first     = (i_command == CMD_LOAD) ? i_position : i_left;
        w_item.second    = w_second[POS_W-1:0];
        w_item.level     = w_level;
        w_item.bad_range = w_bad;
        w_item.value     = i_value;
    end

    // unused command code is taken and dropped
    assign w_keep = i_push && (i_command != CMD_NONE);

    stmin_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_keep),
        .i_data  (w_item),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (w_qdata),
        .o_empty (o_empty)
    );

    assign o_item = t_item'(w_qdata);

endmodule

### rtl/core/stmin_back.sv
// back end: table store, load writes, level build sequencer and query reads
`timescale 1ns / 1ps

module stmin_back
    import stmin_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int LEVELS       = DEF_LEVELS,
    parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr,
    input  logic [CNT_W-1:0] i_active,
    input  t_item            i_item,
    input  logic             i_valid,
    output logic             o_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output t_result          o_result
);

    localparam int IW    = $clog2(MAX_ELEMENTS);
    localparam int LW    = $clog2(LEVELS);
    localparam int AW    = LW + IW;
    localparam int DEPTH = LEVELS * (2 ** IW);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BUILD = 2'd1;
    localparam logic [1:0] S_QRES  = 2'd2;

    logic [1:0]             r_state, n_state;
    logic                   r_built, n_built;
    logic [LW-1:0]          r_lvl, n_lvl;
    logic [IW-1:0]          r_idx, n_idx;
    logic                   r_wr_pend, n_wr_pend;
    logic [AW-1:0]          r_wr_addr, n_wr_addr;
    logic [STATUS_W-1:0]    r_status, n_status;

    logic                   w_load_we;
    logic [AW-1:0]          w_load_addr;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [AW-1:0]          w_raddr_a, w_raddr_b;
    logic [VALUE_WIDTH-1:0] w_rdata_a, w_rdata_b;
    logic [VALUE_WIDTH-1:0] w_min;
    logic [31:0]            w_half;
    logic                   w_issue;

    stmin_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    assign w_min   = ($signed(w_rdata_a) <= $signed(w_rdata_b)) ? w_rdata_a : w_rdata_b;
    assign w_half  = 32'd1 << (32'(r_lvl) - 32'd1);
    assign w_issue = (32'(r_idx) + w_half) < 32'(i_active);

    // build writes land in the cycle after their reads, loads write at once
    assign w_we    = r_wr_pend || w_load_we;
    assign w_waddr = r_wr_pend ? r_wr_addr : w_load_addr;
    assign w_wdata = r_wr_pend ? w_min : VALUE_WIDTH'($signed(i_item.value));

    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_lvl       = r_lvl;
        n_idx       = r_idx;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_status    = r_status;
        o_pop       = 1'b0;
        o_res_push  = 1'b0;
        w_load_we   = 1'b0;
        w_load_addr = {LW'(0), IW'(i_item.first)};
        w_raddr_a   = {LW'(i_item.level), IW'(i_item.first)};
        w_raddr_b   = {LW'(i_item.level), IW'(i_item.second)};
        o_result.status  = r_status;
        o_result.minimum = (r_status == STATUS_OK) ? DATA_W'($signed(w_min)) : '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.cmd)
                        CMD_LOAD: begin
                            o_pop   = 1'b1;
                            n_built = 1'b0;
                            if (32'(i_item.first) < 32'(MAX_ELEMENTS)) begin
                                w_load_we = 1'b1;
                            end
                        end
                        CMD_BUILD: begin
                            o_pop   = 1'b1;
                            n_lvl   = LW'(1);
                            n_idx   = '0;
                            n_state = S_BUILD;
                        end
                        CMD_QUERY: begin
                            if (!i_res_full) begin
                                o_pop   = 1'b1;
                                n_state = S_QRES;
                                priority if (!r_built) begin
                                    n_status = STATUS_UNBUILT;
                                end else if (i_item.bad_range) begin
                                    n_status = STATUS_RANGE;
                                end else begin
                                    n_status = STATUS_OK;
                                end
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_BUILD: begin
                w_raddr_a = {r_lvl - LW'(1), r_idx};
                w_raddr_b = {r_lvl - LW'(1), IW'(32'(r_idx) + w_half)};
                if (w_issue) begin
                    n_wr_pend = 1'b1;
                    n_wr_addr = {r_lvl, r_idx};
                    n_idx     = r_idx + IW'(1);
                end else begin
                    n_idx = '0;
                    if (32'(r_lvl) == LEVELS - 1) begin
                        n_state = S_IDLE;
                        n_built = 1'b1;
                    end else begin
                        n_lvl = r_lvl + LW'(1);
                    end
                end
            end
            S_QRES: begin
                o_res_push = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_wr) begin
            n_built = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_built   <= 1'b0;
            r_lvl     <= '0;
            r_idx     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_built   <= n_built;
            r_lvl     <= n_lvl;
            r_idx     <= n_idx;
            r_wr_pend <= n_wr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_status  <= n_status;
    end

endmodule

### rtl/core/sparse_table_range_min.sv
// top level of the sparse table range minimum engine
//
// items enter through a queue port: an item is taken when push is high and
// full is low. command 0 writes one element, 1 builds the upper table levels,
// 2 asks for the minimum over [left, right]; code 3 is taken and dropped.
// only queries give a result. results leave through a queue port: the oldest
// is on o_minimum/o_status while empty is low and is taken with pop.
// element_count is written on the cfg channel (ready is always high); the
// user must write it only while the engine is idle, which the block does not
// enforce; a write clears the built mark. the back end takes an item from
// the input queue while it is idle; a load writes in that cycle, a query reads
// the table in that cycle and compares in the next, where it pushes its
// result, so no new item is taken before that push. loads run at one per
// cycle while the single table sequencer is idle; queries wait while the
// result queue is full. a build steps levels 1 to LEVELS-1, one read pair per
// cycle, for each i with i + 2^(j-1) < n at level j, n the saturated count.
// reset: count 1024, table not built, table contents undefined with no
// clearing pass. when the receiver stalls, two results wait in the result
// queue, then queries hold, the two-entry input queue fills and full rises.
`timescale 1ns / 1ps

module sparse_table_range_min
    import stmin_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int LEVELS       = DEF_LEVELS,
    parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CNT_W-1:0]    i_cfg_data,
    input  logic                push,
    output logic                full,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [POS_W-1:0]    i_position,
    input  logic [DATA_W-1:0]   i_value,
    input  logic [POS_W-1:0]    i_left,
    input  logic [POS_W-1:0]    i_right,
    output logic                empty,
    input  logic                pop,
    output logic [DATA_W-1:0]   o_minimum,
    output logic [STATUS_W-1:0] o_status
);

    logic             w_cfg_wr;
    logic [CNT_W-1:0] w_active;
    t_item            w_item;
    logic             w_item_empty;
    logic             w_item_pop;
    logic             w_res_full;
    logic             w_res_push;
    t_result          w_result;
    t_result          w_res_out;
    logic [$bits(t_result)-1:0] w_res_data;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    stmin_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (w_cfg_wr),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .o_full     (full),
        .i_command  (i_command),
        .i_position (i_position),
        .i_value    (i_value),
        .i_left     (i_left),
        .i_right    (i_right),
        .o_active   (w_active),
        .i_pop      (w_item_pop),
        .o_item     (w_item),
        .o_empty    (w_item_empty)
    );

    stmin_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (w_cfg_wr),
        .i_active   (w_active),
        .i_item     (w_item),
        .i_valid    (!w_item_empty),
        .o_pop      (w_item_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_result   (w_result)
    );

    stmin_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_result),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_data),
        .o_empty (empty)
    );

    assign w_res_out = t_result'(w_res_data);
    assign o_minimum = w_res_out.minimum;
    assign o_status  = w_res_out.status;

endmodule
